FILE: hw/rtl/bde_pkg.sv
// bde_pkg: request codes, status codes and shared structs for the deque engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bde_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    localparam int          CountW    = 5;
    localparam int          DataW     = 32;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // memory command issued in the accept cycle
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

    // result fields known at accept time, paired with read data in the following cycle
    typedef struct packed {
        logic              use_rd_data;
        t_status           status;
        logic [CountW-1:0] occupancy;
    } t_rsp_info;

endpackage

FILE: hw/rtl/bde_ring_mem.sv
// bde_ring_mem: single-port ring store with registered read data
// depends on bde_pkg
`timescale 1ns / 1ps

module bde_ring_mem #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  logic                  i_clk,
    input  bde_pkg::t_mem_cmd     i_cmd,
    input  logic [PTR_W-1:0]      i_addr,
    input  logic [bde_pkg::DataW-1:0] i_wdata,
    output logic [bde_pkg::DataW-1:0] o_rdata
);
    import bde_pkg::*;

    logic [DataW-1:0] mem [DEPTH];
    logic [DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bde_ctrl.sv
// bde_ctrl: head/tail pointers, word count and capacity register
// depends on bde_pkg; drives the ring store command and the response info
`timescale 1ns / 1ps

module bde_ctrl #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bde_pkg::CountW-1:0]  i_cfg_wdata,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    output bde_pkg::t_mem_cmd           o_cmd,
    output logic [PTR_W-1:0]            o_addr,
    output bde_pkg::t_rsp_info          o_info
);
    import bde_pkg::*;

    localparam int                CapMax   = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [CountW-1:0] CAP_SAT  = CountW'(CapMax);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CountW-1:0] r_count, n_count;
    logic [CountW-1:0] r_cap;
    t_rsp_info         r_info, n_info;

    logic [CountW-1:0] eff_cap;
    logic              full, empty;
    logic [PTR_W-1:0]  head_prev, head_next, tail_prev, tail_next;
    t_mem_cmd          cmd;
    logic [PTR_W-1:0]  addr;

    assign eff_cap   = (r_cap > CAP_SAT) ? CAP_SAT : r_cap;
    assign full      = (r_count >= eff_cap);
    assign empty     = (r_count == '0);
    assign head_prev = (r_head == '0)      ? PTR_LAST : r_head - 1'b1;
    assign head_next = (r_head == PTR_LAST) ? '0      : r_head + 1'b1;
    assign tail_prev = (r_tail == '0)      ? PTR_LAST : r_tail - 1'b1;
    assign tail_next = (r_tail == PTR_LAST) ? '0      : r_tail + 1'b1;

    always_comb begin
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        cmd              = '0;
        addr             = r_head;
        n_info.use_rd_data = 1'b0;
        n_info.status      = ST_OK;
        unique case (t_req'(i_req_type))
            REQ_PUSH_FRONT: begin
                addr = head_prev;
                if (full) begin
                    n_info.status = ST_OVERFLOW;
                end else begin
                    cmd.wr_en = 1'b1;
                    n_head    = head_prev;
                    n_count   = r_count + 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                addr = r_tail;
                if (full) begin
                    n_info.status = ST_OVERFLOW;
                end else begin
                    cmd.wr_en = 1'b1;
                    n_tail    = tail_next;
                    n_count   = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                addr = r_head;
                if (empty) begin
                    n_info.status = ST_EMPTY;
                end else begin
                    cmd.rd_en          = 1'b1;
                    n_info.use_rd_data = 1'b1;
                    n_head             = head_next;
                    n_count            = r_count - 1'b1;
                end
            end
            REQ_POP_REAR: begin
                addr = tail_prev;
                if (empty) begin
                    n_info.status = ST_EMPTY;
                end else begin
                    cmd.rd_en          = 1'b1;
                    n_info.use_rd_data = 1'b1;
                    n_tail             = tail_prev;
                    n_count            = r_count - 1'b1;
                end
            end
            default: begin
                n_info.status = ST_OK;
            end
        endcase
        n_info.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info <= n_info;
        end
    end

    assign o_cmd.wr_en = cmd.wr_en & i_accept;
    assign o_cmd.rd_en = cmd.rd_en & i_accept;
    assign o_addr      = addr;
    assign o_info      = r_info;

endmodule

FILE: hw/rtl/bounded_deque_engine_unit.sv
// bounded_deque_engine_unit: top level of the bounded deque engine
// depends on bde_pkg, bde_ctrl and bde_ring_mem
`timescale 1ns / 1ps

// usage
//   request channel: i_req_valid / o_req_ready carry i_req_type and
//   i_push_value; a transfer happens when both are high at a clock edge
//   response channel: o_rsp_valid / i_rsp_ready carry o_pop_value,
//   o_status, o_occupancy and o_empty_flag, one response per request
//   capacity: i_cfg_we writes i_cfg_wdata into the capacity register at once;
//   write it only while no request is in flight
//   path: a transferred request's response passes through the ring store's
//   registered read port and then the output register
//   overlap: no new request is taken while one is in flight; the single read
//   port of the ring store is busy for the cycle after a transfer and the next
//   request waits for the response to land in the output register
//   reset: synchronous, active low; pointers and count go to zero, capacity
//   to 16, no response pending; ring store contents are not cleared
//   stall: while i_rsp_ready is low the response is held and o_req_ready
//   stays low, so nothing is lost or repeated
module bounded_deque_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bde_pkg::CountW-1:0]  i_cfg_wdata,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [1:0]                  i_req_type,
    input  logic signed [31:0]          i_push_value,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic signed [31:0]          o_pop_value,
    output logic [1:0]                  o_status,
    output logic [bde_pkg::CountW-1:0]  o_occupancy,
    output logic                        o_empty_flag
);
    import bde_pkg::*;

    localparam int PtrW = $clog2(DEPTH);

    logic              accept;
    t_mem_cmd          mem_cmd;
    logic [PtrW-1:0]   mem_addr;
    logic [DataW-1:0]  mem_rdata;
    t_rsp_info         info;

    // response pipeline: pending flag marks read data arriving this cycle
    logic              r_pend;
    logic              r_out_valid;
    logic [DataW-1:0]  r_pop_value, n_pop_value;
    t_status           r_status;
    logic [CountW-1:0] r_occupancy;

    // accept only when the read port is free and the output slot frees up
    assign o_req_ready = !r_pend && (!r_out_valid || i_rsp_ready);
    assign accept      = i_req_valid && o_req_ready;

    bde_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PtrW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .o_cmd       (mem_cmd),
        .o_addr      (mem_addr),
        .o_info      (info)
    );

    bde_ring_mem #(
        .DEPTH (DEPTH),
        .PTR_W (PtrW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

    // popped word, all ones on an empty pop, zero for any push
    always_comb begin
        if (info.use_rd_data) begin
            n_pop_value = mem_rdata;
        end else if (info.status == ST_EMPTY) begin
            n_pop_value = '1;
        end else begin
            n_pop_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= accept;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_pop_value <= n_pop_value;
            r_status    <= info.status;
            r_occupancy <= info.occupancy;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_pop_value  = r_pop_value;
    assign o_status     = r_status;
    assign o_occupancy  = r_occupancy;
    assign o_empty_flag = (r_occupancy == '0);

endmodule

FILE: tb/deque_response_checker.sv
// deque_response_checker: tracks deque state from the request, config and response
// channels, predicts each response and compares it; depends on bde_pkg
`timescale 1ns / 1ps

module deque_response_checker #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bde_pkg::CountW-1:0]  i_cfg_wdata,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [1:0]                  i_req_type,
    input  logic signed [31:0]          i_push_value,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic signed [31:0]          i_pop_value,
    input  logic [1:0]                  i_status,
    input  logic [bde_pkg::CountW-1:0]  i_occupancy,
    input  logic                        i_empty_flag,
    output int                          o_fail_count,
    output int                          o_pending
);
    import bde_pkg::*;

    localparam int MaxPrinted = 40;

    typedef struct packed {
        logic [31:0]       pop_value;
        t_status           status;
        logic [CountW-1:0] occupancy;
        logic              empty_flag;
    } t_deque_rsp;

    // shadow copy of the deque
    logic [31:0]       words [DEPTH];
    int                front_slot;
    int                back_slot;
    int                held;
    logic [CountW-1:0] cap_limit;

    t_deque_rsp        awaited_rsp [$];
    int                rsp_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        rsp_seen     = 0;
    end

    function automatic int step_back(input int slot);
        return (slot == 0) ? DEPTH - 1 : slot - 1;
    endfunction

    function automatic int step_fwd(input int slot);
        return (slot + 1 >= DEPTH) ? 0 : slot + 1;
    endfunction

    // applies one request to the shadow deque and returns its response
    function automatic t_deque_rsp apply_request(input t_req kind, input logic [31:0] word);
        t_deque_rsp rsp;
        int         room;
        room = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
        rsp.pop_value = '0;
        rsp.status    = ST_OK;
        if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_REAR) begin
            if (held >= room) begin
                rsp.status = ST_OVERFLOW;
            end else if (kind == REQ_PUSH_FRONT) begin
                front_slot = step_back(front_slot);
                words[front_slot] = word;
                held++;
            end else begin
                words[back_slot] = word;
                back_slot = step_fwd(back_slot);
                held++;
            end
        end else if (held == 0) begin
            rsp.status    = ST_EMPTY;
            rsp.pop_value = '1;
        end else if (kind == REQ_POP_FRONT) begin
            rsp.pop_value = words[front_slot];
            front_slot = step_fwd(front_slot);
            held--;
        end else begin
            back_slot = step_back(back_slot);
            rsp.pop_value = words[back_slot];
            held--;
        end
        rsp.occupancy  = held[CountW-1:0];
        rsp.empty_flag = (held == 0);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MaxPrinted)
            $display("response %0d: %s is %0h, predicted %0h", rsp_seen, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_deque_rsp want;
        if (!i_rst_n) begin
            front_slot = 0;
            back_slot  = 0;
            held       = 0;
            cap_limit  = CAP_RESET;
            awaited_rsp.delete();
        end else begin
            if (i_cfg_we)
                cap_limit = i_cfg_wdata;
            // responses first: one landing now belongs to an older request
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp.size() == 0) begin
                    report_mismatch("unpredicted response, pop_value", i_pop_value, '0);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_pop_value !== want.pop_value)
                        report_mismatch("pop_value", i_pop_value, want.pop_value);
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(i_occupancy), 32'(want.occupancy));
                    if (i_empty_flag !== want.empty_flag)
                        report_mismatch("empty_flag", 32'(i_empty_flag),
                                        32'(want.empty_flag));
                end
                rsp_seen++;
            end
            if (i_req_valid && i_req_ready)
                awaited_rsp.push_back(apply_request(t_req'(i_req_type), i_push_value));
        end
        o_pending = awaited_rsp.size();
    end

endmodule

FILE: tb/bounded_deque_engine_unit_test.sv
// bounded_deque_engine_unit_test: stimulus, response stalls and verdict for the deque engine
// depends on bde_pkg, bounded_deque_engine_unit and deque_response_checker
`timescale 1ns / 1ps

module bounded_deque_engine_unit_test;
    import bde_pkg::*;

    localparam int TotalRequests = 650;
    localparam int StuckLimit    = 4000;   // cycles with no transfer before giving up
    localparam int DrainPause    = 4;      // idle wait after the checker's queue of predicted responses drains

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CountW-1:0]    i_cfg_wdata;
    logic                 i_req_valid;
    logic                 o_req_ready;
    logic [1:0]           i_req_type;
    logic signed [31:0]   i_push_value;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready = 1'b0;
    logic signed [31:0]   o_pop_value;
    logic [1:0]           o_status;
    logic [CountW-1:0]    o_occupancy;
    logic                 o_empty_flag;

    int fail_count;
    int pending;
    int requests_sent = 0;
    int stuck_cycles  = 0;
    int rsp_hold      = 0;

    // when set, that side runs back to back with no idle cycles
    logic req_burst = 1'b0;
    logic rsp_burst = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bounded_deque_engine_unit #(
        .DEPTH(16)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy),
        .o_empty_flag (o_empty_flag)
    );

    deque_response_checker #(
        .DEPTH(16)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_pop_value  (o_pop_value),
        .i_status     (o_status),
        .i_occupancy  (o_occupancy),
        .i_empty_flag (o_empty_flag),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // response side: random stalls, none at all during a burst stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            rsp_hold    <= 0;
        end else if (rsp_hold != 0) begin
            i_rsp_ready <= 1'b0;
            rsp_hold    <= rsp_hold - 1;
        end else if (!rsp_burst && $urandom_range(0, 3) == 0) begin
            i_rsp_ready <= 1'b0;
            rsp_hold    <= idle_len();
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // watchdog: a stretch with no transfer on either channel means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= StuckLimit) begin
            $display("bounded_deque_engine_unit verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // one request transfer; valid stays up across back-to-back requests
    task automatic send_request(input t_req kind, input logic [31:0] word);
        int gap;
        gap = req_burst ? 0 : idle_len();
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= kind;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_req_ready);
        requests_sent++;
    endtask

    // stop requesting and wait until every predicted response has come back
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainPause) @(posedge i_clk);
    endtask

    // capacity writes only happen with the engine idle
    task automatic write_capacity(input logic [CountW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // push values lean on the corner words now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [CountW-1:0] cap;
        int                push_pct;
        int                phase_len;
        int                phase_no;
        t_req              kind;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        i_req_valid  <= 1'b0;
        i_req_type   <= REQ_PUSH_FRONT;
        i_push_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity: empty pops at both ends, corner words through every op
        send_request(REQ_POP_FRONT, 32'h1234_5678);
        send_request(REQ_POP_REAR, 32'h0);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_REAR, 32'h8000_0000);
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_REAR, 32'h0000_0000);
        send_request(REQ_POP_REAR, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_REAR, 32'h0);
        send_request(REQ_PUSH_REAR, 32'h0000_0001);
        send_request(REQ_PUSH_REAR, 32'h0000_0002);
        send_request(REQ_PUSH_FRONT, 32'h0000_0003);
        drain_responses();

        // capacity dropped below the three words held: pushes refused until pops catch up
        write_capacity(5'd2);
        send_request(REQ_PUSH_FRONT, 32'hAAAA_5555);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_PUSH_REAR, 32'h5555_AAAA);
        send_request(REQ_POP_REAR, 32'h0);
        send_request(REQ_PUSH_REAR, 32'hDEAD_0001);
        drain_responses();

        // zero capacity counts as full; pops still drain what is held
        write_capacity(5'd0);
        send_request(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
        send_request(REQ_PUSH_REAR, 32'hF0F0_F0F0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_REAR, 32'h0);
        drain_responses();

        // random phases, each with its own capacity, op mix and idling style
        phase_no = 0;
        while (requests_sent < TotalRequests) begin
            case (phase_no % 8)
                0: cap = 5'd31;   // above depth, saturates at a full ring
                1: cap = 5'd1;
                2: cap = 5'd16;
                3: cap = 5'd0;
                4: cap = 5'd17;
                5: cap = 5'd2;
                6: cap = 5'd15;
                default: cap = CountW'($urandom_range(0, 31));
            endcase
            write_capacity(cap);

            // first phase fills hard so the saturated capacity overflows
            if (phase_no == 0)
                push_pct = 85;
            else
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
            phase_len = (phase_no == 0) ? 45 : $urandom_range(20, 60);

            repeat (phase_len) begin
                if ($urandom_range(0, 99) < push_pct)
                    kind = t_req'($urandom_range(0, 1));
                else
                    kind = t_req'($urandom_range(2, 3));
                send_request(kind, pick_word());
            end
            drain_responses();
            phase_no++;
        end

        // quiet tail so a stray extra response still gets caught
        rsp_burst = 1'b1;
        repeat (DrainPause * 2) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_deque_engine_unit verification clean");
        end else begin
            $display("bounded_deque_engine_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bde_pkg.sv
hw/rtl/bde_ring_mem.sv
hw/rtl/bde_ctrl.sv
hw/rtl/bounded_deque_engine_unit.sv
tb/deque_response_checker.sv
tb/bounded_deque_engine_unit_test.sv
